// ===== rtl/named_aligned_area_reserver_core_assert.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the named aligned area reserver
// Clocked on clk, disabled while arst_n is low; empty when synthesising.
// -----------------------------------------------------------------------------
`ifndef NAMED_ALIGNED_AREA_RESERVER_CORE_ASSERT_SVH
`define NAMED_ALIGNED_AREA_RESERVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define NAAR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define NAAR_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |-> post) else $error(msg);
`define NAAR_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);
`else
`define NAAR_ASSERT(lbl, prop, msg)
`define NAAR_ASSERT_IMPL(lbl, pre, post, msg)
`define NAAR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/naar_pkg.sv =====
// -----------------------------------------------------------------------------
// naar_pkg
// Types and constants shared by the area reserver front, back and top level.
// -----------------------------------------------------------------------------
package naar_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = QPTR_W + 1;

	localparam int ADDR_W = 32;
	localparam int TOP_W  = 33;
	localparam int SIZE_W = 25;
	localparam int KEY_W  = 16;

	localparam logic [TOP_W-1:0] TOP_LIMIT = 33'h1_0000_0000;
	localparam logic [TOP_W-1:0] FREE_MAX  = 33'h0_01FF_FFFF;

	// command codes as seen on the input word
	localparam logic [1:0] CMD_RESERVE = 2'd0;
	localparam logic [1:0] CMD_QUERY   = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	// register indexes (paddr[2])
	localparam logic REG_BASE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	typedef enum logic [1:0] {
		OP_RESERVE,
		OP_QUERY,
		OP_CLEAR,
		OP_IGNORE
	} op_t;

	typedef enum logic [2:0] {
		ST_NEW       = 3'd0,
		ST_EXISTING  = 3'd1,
		ST_NOT_READY = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_NO_SPACE  = 3'd4,
		ST_FULL      = 3'd5,
		ST_NOT_FOUND = 3'd6,
		ST_CLEARED   = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PREP,
		BK_SCAN,
		BK_DECIDE,
		BK_EMIT
	} bk_state_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [KEY_W-1:0]  area_key;
		logic [SIZE_W-1:0] area_size;
		logic [SIZE_W-1:0] alignment;
	} in_word_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] area_address;
		logic [SIZE_W-1:0] free_bytes;
	} out_word_t;

	// classified command as held in the queue between front and back
	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] mask;
		logic              align_ok;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [SIZE_W-1:0] size;
	} cfg_t;

endpackage

// ===== rtl/naar_front.sv =====
// -----------------------------------------------------------------------------
// naar_front
// Accepts input words, classifies them and holds them in a short queue.
// -----------------------------------------------------------------------------
module naar_front import naar_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_word_t req,
	output item_t    item,
	output logic     item_valid,
	input  logic     item_pop
);

	item_t             cls;
	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              enq;
	logic              deq;

	// decode the command and pre-digest the alignment
	always_comb begin
		cls.key      = req.area_key;
		cls.size     = req.area_size;
		cls.align_ok = (req.alignment & (req.alignment - SIZE_W'(1))) == '0;
		cls.mask     = (req.alignment == '0) ? '0 : req.alignment - SIZE_W'(1);
		unique case (req.command)
			CMD_RESERVE: cls.op = OP_RESERVE;
			CMD_QUERY:   cls.op = OP_QUERY;
			CMD_CLEAR:   cls.op = OP_CLEAR;
			default:     cls.op = OP_IGNORE;
		endcase
	end

	assign full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign item_valid = count_q != '0;
	assign item       = mem_q[rd_ptr_q];
	assign enq        = push && !full;
	assign deq        = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({enq, deq})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/naar_back.sv =====
// -----------------------------------------------------------------------------
// naar_back
// Executes classified commands: table scan, top pointer update, result word.
// -----------------------------------------------------------------------------
`include "named_aligned_area_reserver_core_assert.svh"

module naar_back import naar_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  item_t     item,
	input  logic      item_valid,
	output logic      item_pop,
	output out_word_t rsp,
	output logic      rsp_valid,
	input  logic      rsp_pop
);

	bk_state_t state_q, state_d;

	item_t             item_q;
	logic [TOP_W-1:0]  top_q;
	logic [TABLE_DEPTH-1:0] tbl_valid_q;
	logic [KEY_W-1:0]  tbl_key_q  [TABLE_DEPTH];
	logic [ADDR_W-1:0] tbl_addr_q [TABLE_DEPTH];

	// values prepared ahead of the decision
	logic              ready_q;
	logic [TOP_W-1:0]  diff_q;
	logic [TOP_W-1:0]  start_q;
	logic [TOP_W-1:0]  end_q;

	// scan results
	logic [IDX_W-1:0]  idx_q;
	logic              hit_q;
	logic [ADDR_W-1:0] hit_addr_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;

	// decision results
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_addr_q;

	out_word_t         out_q;
	logic              out_valid_q;

	logic take_en, prep_en, scan_en, decide_en, emit_en;

	logic [TOP_W-1:0]  base_ext;
	logic [TOP_W-1:0]  size_ext;
	logic [TOP_W-1:0]  sum_ext;
	logic              scan_last;

	status_t           dec_status;
	logic [ADDR_W-1:0] dec_addr;
	logic              dec_new;
	logic              dec_clear;

	logic              emit_ready;
	logic [TOP_W-1:0]  emit_diff;
	logic [SIZE_W-1:0] emit_free;

	assign base_ext  = {1'b0, cfg.base};
	assign size_ext  = {{(TOP_W-SIZE_W){1'b0}}, item_q.size};
	assign sum_ext   = base_ext + {{(TOP_W-SIZE_W){1'b0}}, cfg.size};
	assign scan_last = idx_q == IDX_W'(TABLE_DEPTH - 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:   if (item_valid) state_d = BK_PREP;
			BK_PREP:   state_d = BK_SCAN;
			BK_SCAN:   if (scan_last) state_d = BK_DECIDE;
			BK_DECIDE: state_d = BK_EMIT;
			BK_EMIT:   if (!out_valid_q || rsp_pop) state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		take_en   = 1'b0;
		prep_en   = 1'b0;
		scan_en   = 1'b0;
		decide_en = 1'b0;
		emit_en   = 1'b0;
		unique case (state_q)
			BK_IDLE:   take_en   = item_valid;
			BK_PREP:   prep_en   = 1'b1;
			BK_SCAN:   scan_en   = 1'b1;
			BK_DECIDE: decide_en = 1'b1;
			BK_EMIT:   emit_en   = !out_valid_q || rsp_pop;
			default:   take_en   = 1'b0;
		endcase
	end

	assign item_pop = take_en;

	// decision on the prepared values and scan results
	always_comb begin
		dec_status = ST_NOT_READY;
		dec_addr   = '0;
		dec_new    = 1'b0;
		dec_clear  = 1'b0;
		case (item_q.op)
			OP_CLEAR: begin
				dec_status = ST_CLEARED;
				dec_clear  = 1'b1;
			end
			OP_QUERY: begin
				if (hit_q) begin
					dec_status = ST_EXISTING;
					dec_addr   = hit_addr_q;
				end else begin
					dec_status = ST_NOT_FOUND;
				end
			end
			OP_RESERVE: begin
				if (item_q.size == '0 || !ready_q || !item_q.align_ok) begin
					dec_status = ST_NOT_READY;
				end else if (size_ext > diff_q) begin
					dec_status = ST_TOO_LARGE;
				end else if (hit_q) begin
					dec_status = ST_EXISTING;
					dec_addr   = hit_addr_q;
				end else if (start_q <= base_ext) begin
					dec_status = ST_NO_SPACE;
				end else if (!free_q) begin
					dec_status = ST_FULL;
				end else begin
					dec_status = ST_NEW;
					dec_addr   = start_q[ADDR_W-1:0];
					dec_new    = 1'b1;
				end
			end
			default: dec_status = ST_NOT_READY;
		endcase
	end

	// free space after the step, saturated to the field width
	always_comb begin
		emit_ready = (cfg.size != '0) && (top_q > base_ext);
		emit_diff  = top_q - base_ext;
		if (!emit_ready) begin
			emit_free = '0;
		end else if (emit_diff > FREE_MAX) begin
			emit_free = '1;
		end else begin
			emit_free = emit_diff[SIZE_W-1:0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_en) begin
			item_q <= item;
		end
		if (prep_en) begin
			ready_q <= (cfg.size != '0) && (top_q > base_ext);
			diff_q  <= top_q - base_ext;
			start_q <= (top_q - size_ext) & ~{{(TOP_W-SIZE_W){1'b0}}, item_q.mask};
			end_q   <= sum_ext[TOP_W-1] ? TOP_LIMIT : sum_ext;
		end
		if (scan_en) begin
			if (tbl_valid_q[idx_q] && tbl_key_q[idx_q] == item_q.key && !hit_q) begin
				hit_addr_q <= tbl_addr_q[idx_q];
			end
			if (!tbl_valid_q[idx_q] && !free_q) begin
				free_idx_q <= idx_q;
			end
		end
		if (decide_en) begin
			res_status_q <= dec_status;
			res_addr_q   <= dec_addr;
			if (dec_new) begin
				tbl_key_q[free_idx_q]  <= item_q.key;
				tbl_addr_q[free_idx_q] <= dec_addr;
			end
		end
		if (emit_en) begin
			out_q.status       <= res_status_q;
			out_q.area_address <= res_addr_q;
			out_q.free_bytes   <= emit_free;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			top_q       <= '0;
			tbl_valid_q <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (prep_en) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end
			if (scan_en) begin
				if (tbl_valid_q[idx_q] && tbl_key_q[idx_q] == item_q.key) begin
					hit_q <= 1'b1;
				end
				if (!tbl_valid_q[idx_q]) begin
					free_q <= 1'b1;
				end
				if (!scan_last) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			if (decide_en) begin
				if (dec_clear) begin
					tbl_valid_q <= '0;
					top_q       <= end_q;
				end else if (dec_new) begin
					tbl_valid_q[free_idx_q] <= 1'b1;
					top_q                   <= start_q;
				end
			end
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (rsp_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

	`NAAR_ASSERT(a_top_in_range, top_q <= TOP_LIMIT, "top pointer beyond address space")
	`NAAR_ASSERT_NEXT(a_top_falls, (decide_en && item_q.op != OP_CLEAR), (top_q <= $past(top_q)), "top pointer rose without clear")
	`NAAR_ASSERT_NEXT(a_clear_empties, (decide_en && item_q.op == OP_CLEAR), (tbl_valid_q == '0), "table not emptied by clear")
	`NAAR_ASSERT_IMPL(a_new_nonzero, (emit_en && res_status_q == ST_NEW), (res_addr_q != '0), "new area at address zero")

endmodule

// ===== rtl/named_aligned_area_reserver_core.sv =====
// -----------------------------------------------------------------------------
// named_aligned_area_reserver_core
// Top-down allocator of named, aligned areas in a scratch memory region.
// -----------------------------------------------------------------------------
// Usage:
//   Commands enter as a queue: drive req and raise push while full is low.
//   Results leave as a queue: while empty is low, rsp holds the oldest word;
//   raise pop to take it. Every command gives exactly one result word.
//   region_base (0x0) and region_size (0x4) are set over the APB port; write
//   them only while the block is idle, then issue a clear to load the top
//   pointer. Nothing can be reserved before the first clear.
// Flow:
//   On an idle block the back end takes a command and steps it through
//   prepare, scan and decide to emit, where its result word is registered
//   onto rsp; the key table is scanned one entry per cycle. The back end
//   takes the next command only once the last has been emitted. Two more
//   commands queue at the input while one is executed.
// Reset:
//   arst_n empties both queues, invalidates the table, zeroes the top
//   pointer and the registers. No clearing pass is needed.
// Stall:
//   While a result waits unpopped the back end holds its next result and
//   the input queue fills; full then holds off push. Nothing is dropped.
// -----------------------------------------------------------------------------
module named_aligned_area_reserver_core import naar_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// command queue
	input  logic        push,
	output logic        full,
	input  in_word_t    req,
	// result queue
	output logic        empty,
	input  logic        pop,
	output out_word_t   rsp,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t  cfg_q;
	item_t item;
	logic  item_valid;
	logic  item_pop;
	logic  rsp_valid;
	logic  reg_wr;

	// Registers: always ready, write on the access phase.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (reg_wr) begin
			unique case (paddr[2])
				REG_BASE: cfg_q.base <= pwdata;
				REG_SIZE: cfg_q.size <= pwdata[SIZE_W-1:0];
				default:  cfg_q      <= cfg_q;
			endcase
		end
	end

	// Read back: size zero-extended to the bus width.
	always_comb begin
		unique case (paddr[2])
			REG_BASE: prdata = cfg_q.base;
			REG_SIZE: prdata = {{(32-SIZE_W){1'b0}}, cfg_q.size};
			default:  prdata = '0;
		endcase
	end

	// Front: classify each word and hold it until the back end is free.
	naar_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req        (req),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	// Back: scan the table, decide, advance the top pointer, register result.
	naar_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.rsp        (rsp),
		.rsp_valid  (rsp_valid),
		.rsp_pop    (pop)
	);

	assign empty = !rsp_valid;

endmodule
